// ===== rtl/core/pscd_pkg.sv =====
// Shared types and constants for the closest-point-on-segment core.
package pscd_pkg;

  localparam int CW     = 32;
  localparam int PFB    = 16;
  localparam int SUM_W  = 2 * CW + 4;
  localparam int ROOT_W = SUM_W / 2;
  localparam int PROD_W = 2 * CW + 2;
  localparam int OFF_W  = CW + PFB + 2;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    logic [PFB:0]         seg_param;
    logic [CW-1:0]        distance;
  } out_t;

  typedef struct packed {
    logic zero;
    logic one;
  } clamp_t;

endpackage

// ===== rtl/core/pscd_div.sv =====
// Pipelined restoring divider giving the clamped segment parameter, one quotient bit per stage.
module pscd_div #(
  parameter int NW = pscd_pkg::SUM_W,
  parameter int QW = pscd_pkg::PFB,
  parameter int DW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [NW-1:0]        num_i,
  input  logic [NW-1:0]        den_i,
  input  pscd_pkg::clamp_t     clamp_i,
  input  logic [DW-1:0]        data_i,
  output logic                 valid_o,
  output logic [QW:0]          quo_o,
  output logic [DW-1:0]        data_o
);
  import pscd_pkg::*;

  logic          vld  [QW+1];
  logic [NW-1:0] rem  [QW+1];
  logic [NW-1:0] den  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  clamp_t        clp  [QW+1];
  logic [DW-1:0] dat  [QW+1];

  assign vld[0] = valid_i;
  assign rem[0] = num_i;
  assign den[0] = den_i;
  assign quo[0] = '0;
  assign clp[0] = clamp_i;
  assign dat[0] = data_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_sh;
    logic          ge;
    logic          vld_q;
    logic [NW-1:0] rem_q, den_q;
    logic [QW-1:0] quo_q;
    clamp_t        clp_q;
    logic [DW-1:0] dat_q;

    assign rem_sh = {rem[k][NW-2:0], 1'b0};
    assign ge     = rem_sh >= den[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q <= ge ? rem_sh - den[k] : rem_sh;
      den_q <= den[k];
      quo_q <= {quo[k][QW-2:0], ge};
      clp_q <= clp[k];
      dat_q <= dat[k];
    end

    assign vld[k+1] = vld_q;
    assign rem[k+1] = rem_q;
    assign den[k+1] = den_q;
    assign quo[k+1] = quo_q;
    assign clp[k+1] = clp_q;
    assign dat[k+1] = dat_q;
  end

  assign valid_o = vld[QW];
  assign data_o  = dat[QW];
  assign quo_o   = clp[QW].zero ? '0 :
                   clp[QW].one  ? (QW+1)'(1) << QW : {1'b0, quo[QW]};

endmodule

// ===== rtl/core/pscd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
module pscd_sqrt #(
  parameter int RW = pscd_pkg::ROOT_W,
  parameter int DW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [DW-1:0]   data_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [DW-1:0]   data_o
);
  import pscd_pkg::*;

  localparam int RMW = RW + 4;

  logic            vld  [RW+1];
  logic [2*RW-1:0] rad  [RW+1];
  logic [RMW-1:0]  rem  [RW+1];
  logic [RW-1:0]   root [RW+1];
  logic [DW-1:0]   dat  [RW+1];

  assign vld[0]  = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign dat[0]  = data_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RMW-1:0]  rem_sh, trial;
    logic            ge;
    logic            vld_q;
    logic [2*RW-1:0] rad_q;
    logic [RMW-1:0]  rem_q;
    logic [RW-1:0]   root_q;
    logic [DW-1:0]   dat_q;

    assign rem_sh = {rem[k][RMW-3:0], rad[k][2*RW-1:2*RW-2]};
    assign trial  = RMW'({root[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q  <= {rad[k][2*RW-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root[k][RW-2:0], ge};
      dat_q  <= dat[k];
    end

    assign vld[k+1]  = vld_q;
    assign rad[k+1]  = rad_q;
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign dat[k+1]  = dat_q;
  end

  assign valid_o = vld[RW];
  assign root_o  = root[RW];
  assign data_o  = dat[RW];

endmodule

// ===== rtl/core/point_segment_closest_distance_core.sv =====
// Top level: closest point on a 3D segment, segment parameter and distance.
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+--------------------------------------
//  item in  | start_i, busy_o, item_i | taken when start_i high, busy_o low
//  result   | result_valid_o,result_o | one cycle strobe, no back-pressure
//
// One item accepted per cycle; busy_o stays low.
// The pipeline runs through the 16-stage divider and the 34-stage square root.
// Reset clears the valid bits only; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module point_segment_closest_distance_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pscd_pkg::in_t   item_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output pscd_pkg::out_t  result_o
);
  import pscd_pkg::*;

  localparam int LAT    = 60;
  localparam int DIV_DW = 3 * (CW + 1) + 6 * CW;
  localparam int SQ_DW  = 3 * CW + PFB + 1;
  localparam logic signed [OFF_W-1:0] HALF = OFF_W'(1) << (PFB - 1);

  logic signed [CW-1:0] pt [3], sa [3], ea [3];
  assign pt = '{item_i.point_x, item_i.point_y, item_i.point_z};
  assign sa = '{item_i.start_x, item_i.start_y, item_i.start_z};
  assign ea = '{item_i.end_x, item_i.end_y, item_i.end_z};

  assign busy_o = 1'b0;

  // stage 1: differences
  logic                 v1_q;
  logic signed [CW:0]   d1_q [3], w1_q [3];
  logic signed [CW-1:0] p1_q [3], s1_q [3];
  // stage 2: products
  logic                     v2_q;
  logic signed [PROD_W-1:0] dd2_q [3], wd2_q [3];
  logic signed [CW:0]       d2_q [3];
  logic signed [CW-1:0]     p2_q [3], s2_q [3];
  // stage 3: sums
  logic                    v3_q;
  logic signed [SUM_W-1:0] len3_q, dot3_q;
  logic signed [CW:0]      d3_q [3];
  logic signed [CW-1:0]    p3_q [3], s3_q [3];
  // stage 4: clamp decision
  logic                    v4_q;
  logic signed [SUM_W-1:0] len4_q, dot4_q;
  clamp_t                  clp4_q;
  logic [DIV_DW-1:0]       pay4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      d1_q[a]  <= (CW+1)'(ea[a]) - (CW+1)'(sa[a]);
      w1_q[a]  <= (CW+1)'(pt[a]) - (CW+1)'(sa[a]);
      p1_q[a]  <= pt[a];
      s1_q[a]  <= sa[a];
      dd2_q[a] <= d1_q[a] * d1_q[a];
      wd2_q[a] <= w1_q[a] * d1_q[a];
      d2_q[a]  <= d1_q[a];
      p2_q[a]  <= p1_q[a];
      s2_q[a]  <= s1_q[a];
      d3_q[a]  <= d2_q[a];
      p3_q[a]  <= p2_q[a];
      s3_q[a]  <= s2_q[a];
    end
    len3_q <= SUM_W'(dd2_q[0]) + SUM_W'(dd2_q[1]) + SUM_W'(dd2_q[2]);
    dot3_q <= SUM_W'(wd2_q[0]) + SUM_W'(wd2_q[1]) + SUM_W'(wd2_q[2]);
    len4_q <= len3_q;
    dot4_q <= dot3_q;
    clp4_q.zero <= (len3_q == '0) || dot3_q[SUM_W-1] || (dot3_q == '0);
    clp4_q.one  <= dot3_q >= len3_q;
    pay4_q <= {d3_q[0], d3_q[1], d3_q[2], p3_q[0], p3_q[1], p3_q[2],
               s3_q[0], s3_q[1], s3_q[2]};
  end

  logic              vdiv;
  logic [PFB:0]      udiv;
  logic [DIV_DW-1:0] pdiv;

  pscd_div #(.NW(SUM_W), .QW(PFB), .DW(DIV_DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (dot4_q),
    .den_i   (len4_q),
    .clamp_i (clp4_q),
    .data_i  (pay4_q),
    .valid_o (vdiv),
    .quo_o   (udiv),
    .data_o  (pdiv)
  );

  logic signed [CW:0]   dd [3];
  logic signed [CW-1:0] pd [3], sd [3];
  assign {dd[0], dd[1], dd[2], pd[0], pd[1], pd[2], sd[0], sd[1], sd[2]} = pdiv;

  // stage: offset, near point, error, square, sum
  logic                     v5_q, v6_q, v7_q, v8_q, v9_q;
  logic signed [OFF_W-1:0]  off5_q [3];
  logic signed [CW-1:0]     p5_q [3], s5_q [3], p6_q [3], n6_q [3], n7_q [3], n8_q [3];
  logic signed [CW-1:0]     n9_q [3];
  logic [PFB:0]             u5_q, u6_q, u7_q, u8_q, u9_q;
  logic signed [CW:0]       e7_q [3];
  logic signed [PROD_W-1:0] ee8_q [3];
  logic [SUM_W-1:0]         sq9_q;
  logic signed [OFF_W-1:0]  rnd [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd[a] = (off5_q[a] + HALF) >>> PFB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v5_q <= vdiv;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      off5_q[a] <= dd[a] * $signed({1'b0, udiv});
      p5_q[a]   <= pd[a];
      s5_q[a]   <= sd[a];
      n6_q[a]   <= s5_q[a] + rnd[a][CW-1:0];
      p6_q[a]   <= p5_q[a];
      e7_q[a]   <= (CW+1)'(p6_q[a]) - (CW+1)'(n6_q[a]);
      n7_q[a]   <= n6_q[a];
      ee8_q[a]  <= e7_q[a] * e7_q[a];
      n8_q[a]   <= n7_q[a];
      n9_q[a]   <= n8_q[a];
    end
    u5_q  <= udiv;
    u6_q  <= u5_q;
    u7_q  <= u6_q;
    u8_q  <= u7_q;
    u9_q  <= u8_q;
    sq9_q <= SUM_W'(ee8_q[0]) + SUM_W'(ee8_q[1]) + SUM_W'(ee8_q[2]);
  end

  logic              vsq;
  logic [ROOT_W-1:0] root;
  logic [SQ_DW-1:0]  psq;

  pscd_sqrt #(.RW(ROOT_W), .DW(SQ_DW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v9_q),
    .rad_i   (sq9_q),
    .data_i  ({n9_q[0], n9_q[1], n9_q[2], u9_q}),
    .valid_o (vsq),
    .root_o  (root),
    .data_o  (psq)
  );

  logic valid_q;
  out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    {res_q.near_x, res_q.near_y, res_q.near_z, res_q.seg_param} <= psq;
    res_q.distance <= (root[ROOT_W-1:CW] != '0) ? '1 : root[CW-1:0];
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_param_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.seg_param <= ((PFB+1)'(1) << PFB))
    else $error("segment parameter above one");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, LAT))
    else $error("result without an item accepted");

endmodule

// ===== tb/pscd_checker.sv =====
// Checker for the closest-point-on-segment core: predicts each result and compares it.
`timescale 1ns / 1ps

module pscd_checker
  import pscd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_o,
  input  in_t   item_i,
  input  logic  result_valid_o,
  input  out_t  result_o,
  output int    fail_count_o,
  output int    pending_o
);

  out_t nearest_q[$];
  int   fail_count = 0;

  function automatic out_t nearest_on_segment(in_t it);
    logic signed [127:0] pt [3];
    logic signed [127:0] st [3];
    logic signed [127:0] dir [3];
    logic signed [127:0] len2, dot, off, nr, e, sq, uu;
    logic [127:0] root, trial;
    logic [PFB:0] u;
    logic signed [CW-1:0] nxyz [3];
    out_t res;
    pt[0] = it.point_x;  pt[1] = it.point_y;  pt[2] = it.point_z;
    st[0] = it.start_x;  st[1] = it.start_y;  st[2] = it.start_z;
    dir[0] = it.end_x;   dir[1] = it.end_y;   dir[2] = it.end_z;
    len2 = 0;
    dot = 0;
    for (int a = 0; a < 3; a++) begin
      dir[a] = dir[a] - st[a];
      len2 = len2 + dir[a] * dir[a];
      dot = dot + (pt[a] - st[a]) * dir[a];
    end
    if (len2 == 0 || dot <= 0) begin
      u = '0;
    end else if (dot >= len2) begin
      u = (PFB+1)'(1) << PFB;
    end else begin
      u = (PFB+1)'(($unsigned(dot) << PFB) / $unsigned(len2));
    end
    uu = $signed({111'b0, u});
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      off = dir[a] * uu + (128'sd1 <<< (PFB - 1));
      nr = st[a] + (off >>> PFB);
      e = pt[a] - nr;
      sq = sq + e * e;
      nxyz[a] = nr[CW-1:0];
    end
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= $unsigned(sq)) root = trial;
    end
    res.near_x = nxyz[0];
    res.near_y = nxyz[1];
    res.near_z = nxyz[2];
    res.seg_param = u;
    res.distance = (root > 128'hFFFF_FFFF) ? '1 : root[CW-1:0];
    return res;
  endfunction

  assign pending_o = nearest_q.size();
  assign fail_count_o = fail_count;

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_o) nearest_q.push_back(nearest_on_segment(item_i));
      if (result_valid_o) begin
        if (nearest_q.size() == 0) begin
          $error("result with no item pending");
          fail_count++;
        end else begin
          exp_r = nearest_q.pop_front();
          if (result_o.near_x !== exp_r.near_x) begin
            $error("near_x expected %0d got %0d", exp_r.near_x, result_o.near_x);
            fail_count++;
          end
          if (result_o.near_y !== exp_r.near_y) begin
            $error("near_y expected %0d got %0d", exp_r.near_y, result_o.near_y);
            fail_count++;
          end
          if (result_o.near_z !== exp_r.near_z) begin
            $error("near_z expected %0d got %0d", exp_r.near_z, result_o.near_z);
            fail_count++;
          end
          if (result_o.seg_param !== exp_r.seg_param) begin
            $error("seg_param expected %0d got %0d", exp_r.seg_param, result_o.seg_param);
            fail_count++;
          end
          if (result_o.distance !== exp_r.distance) begin
            $error("distance expected %0d got %0d", exp_r.distance, result_o.distance);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, item stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
  import pscd_pkg::*;

  localparam int LATENCY = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic result_valid_o;
  out_t result_o;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  point_segment_closest_distance_core DUT (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .result_valid_o, .result_o
  );

  pscd_checker checker_inst (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      2: return $signed($urandom_range(0, 2 << 24)) - (1 << 24);
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int mode;
    int shape;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    shape = $urandom_range(0, 9);
    it.point_x = rand_coord(mode); it.point_y = rand_coord(mode); it.point_z = rand_coord(mode);
    it.start_x = rand_coord(mode); it.start_y = rand_coord(mode); it.start_z = rand_coord(mode);
    it.end_x = rand_coord(mode);   it.end_y = rand_coord(mode);   it.end_z = rand_coord(mode);
    if (shape == 0) begin
      it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
    end else if (shape == 1) begin
      it.point_x = it.end_x; it.point_y = it.end_y; it.point_z = it.end_z;
    end else if (shape == 2) begin
      it.point_x = it.start_x; it.point_y = it.start_y; it.point_z = it.start_z;
    end
    return it;
  endfunction

  function automatic in_t make_item(int px, int py, int pz, int sx, int sy, int sz,
                                    int ex, int ey, int ez);
    in_t it;
    it.point_x = px; it.point_y = py; it.point_z = pz;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.end_x = ex;   it.end_y = ey;   it.end_z = ez;
    return it;
  endfunction

  // hold the item until taken; leaves start_i high for the caller
  task automatic send_item(in_t it);
    start_i <= 1'b1;
    item_i <= it;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic idle_for(int n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  in_t directed_q[$];
  int  burst;
  int  sent;
  bit  drained;

  initial begin
    localparam int MAXC = 32'h7FFF_FFFF;
    localparam int MINC = 32'h8000_0000;
    localparam int ONE = 32'h0001_0000;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_item(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_item(-ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
    directed_q.push_back(make_item(0, ONE, 0, 0, 0, 0, ONE, 0, 0));
    directed_q.push_back(make_item(2 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
    directed_q.push_back(make_item(ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
    directed_q.push_back(make_item(ONE / 2, ONE, -ONE, 0, 0, 0, ONE, 0, 0));
    directed_q.push_back(make_item(1, 0, 0, 0, 0, 0, 3, 0, 0));
    directed_q.push_back(make_item(1, 0, 0, 0, 0, 0, -3, 0, 0));
    directed_q.push_back(make_item(0, 0, 0, 0, 0, 0, 1, 1, 1));
    directed_q.push_back(make_item(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC));
    directed_q.push_back(make_item(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    directed_q.push_back(make_item(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC));
    directed_q.push_back(make_item(0, 0, 0, MINC, MINC, MINC, MAXC, MAXC, MAXC));
    directed_q.push_back(make_item(MAXC, 0, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC));
    directed_q.push_back(make_item(MINC, MAXC, 0, MAXC, MINC, 0, MINC, MAXC, 0));
    directed_q.push_back(make_item(MAXC, MAXC, MAXC, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_item(-1, -1, -1, 0, 0, 0, 1, 1, 1));
    directed_q.push_back(make_item(7, -5, 3, -2, 4, 1, 9, -8, 6));
    foreach (directed_q[i]) send_item(directed_q[i]);
    idle_for(3);

    sent = 0;
    drained = 1'b0;
    while (sent < 1400) begin
      if (!drained && sent >= 700) begin
        drained = 1'b1;
        start_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      repeat (burst) begin
        send_item(rand_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end
    start_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pscd_pkg.sv
rtl/core/pscd_div.sv
rtl/core/pscd_sqrt.sv
rtl/core/point_segment_closest_distance_core.sv
tb/pscd_checker.sv
tb/testbench.sv
